>>> rtl/core/bmb_pkg.sv
// Shared types, request codes and defaults for the bounded multiset bag.
package bmb_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int ENTRY_BITS_DEF = 32;

    localparam logic [2:0] FN_ADD      = 3'd0;
    localparam logic [2:0] FN_REMOVE   = 3'd1;
    localparam logic [2:0] FN_COUNT    = 3'd2;
    localparam logic [2:0] FN_CONTAINS = 3'd3;
    localparam logic [2:0] FN_CLEAR    = 3'd4;
    localparam logic [2:0] FN_LIST     = 3'd5;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] entry;
    } bmb_req_t;

    typedef struct packed {
        logic        ok;
        logic [4:0]  match_count;
        logic [4:0]  bag_size;
        logic        bag_empty;
        logic        item_valid;
        logic [31:0] listed_item;
        logic        last;
    } bmb_rsp_t;

    typedef struct packed {
        logic clr;
        logic en;
    } bmb_match_ctl_t;

endpackage

>>> rtl/core/bmb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bmb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/bmb_match.sv
// Shared compare unit: counts matches and keeps the first matching slot seen.
module bmb_match
    import bmb_pkg::*;
#(
    parameter int ENTRY_BITS = ENTRY_BITS_DEF,
    parameter int CNT_W      = 5,
    parameter int AW         = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bmb_match_ctl_t        ctl,
    input  logic [AW-1:0]         idx,
    input  logic [ENTRY_BITS-1:0] key,
    input  logic [ENTRY_BITS-1:0] data,
    output logic [CNT_W-1:0]      count,
    output logic                  hit,
    output logic [AW-1:0]         hit_idx
);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             hit_reg, hit_next;
    logic [AW-1:0]    hit_idx_reg, hit_idx_next;
    logic             eq;

    assign eq = (key == data);

    always_comb
    begin
        count_next   = count_reg;
        hit_next     = hit_reg;
        hit_idx_next = hit_idx_reg;
        if (ctl.clr)
        begin
            count_next = '0;
            hit_next   = 1'b0;
        end
        else if (ctl.en && eq)
        begin
            count_next = count_reg + CNT_W'(1);
            if (!hit_reg)
            begin
                hit_next     = 1'b1;
                hit_idx_next = idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            hit_reg     <= 1'b0;
            hit_idx_reg <= '0;
        end
        else
        begin
            count_reg   <= count_next;
            hit_reg     <= hit_next;
            hit_idx_reg <= hit_idx_next;
        end
    end

    assign count   = count_reg;
    assign hit     = hit_reg;
    assign hit_idx = hit_idx_reg;

endmodule

>>> rtl/core/bounded_multiset_bag.sv
// Bounded multiset bag: sequencer, entry memory and shared compare unit.
// With n held entries (n > 0), add, remove, count and contains keep busy high
// while each held entry is read from the single-port-read entry RAM once per
// cycle and passed through one shared compare unit. A remove whose match is not
// the newest entry then moves each newer entry down one slot to close the gap.
// A list keeps busy high while it gives one result per cycle. On an empty bag,
// and for clear or an unused code, busy is high for one cycle. Results appear
// on result for one cycle with done high. The receiver cannot stall them, so
// there is no back-pressure input. The last result of a request carries last.
module bounded_multiset_bag
    import bmb_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int ENTRY_BITS = ENTRY_BITS_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  bmb_req_t req,
    output logic     done,
    output bmb_rsp_t result
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_SHIFT = 3'd2;
    localparam logic [2:0] ST_LIST  = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [2:0]            func_reg, func_next;
    logic [ENTRY_BITS-1:0] key_reg, key_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [CNT_W-1:0]      ptr_reg, ptr_next;
    logic                  pv_reg, pv_next;
    logic [AW-1:0]         pa_reg, pa_next;
    logic                  done_reg, done_next;
    bmb_rsp_t              result_reg, result_next;

    logic                  we;
    logic [AW-1:0]         waddr, raddr;
    logic [ENTRY_BITS-1:0] wdata, rdata;

    bmb_match_ctl_t        mctl;
    logic [CNT_W-1:0]      m_count;
    logic                  m_hit;
    logic [AW-1:0]         m_hit_idx;

    bmb_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    bmb_match #(
        .ENTRY_BITS (ENTRY_BITS),
        .CNT_W      (CNT_W),
        .AW         (AW)
    ) u_match (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mctl),
        .idx     (pa_reg),
        .key     (key_reg),
        .data    (rdata),
        .count   (m_count),
        .hit     (m_hit),
        .hit_idx (m_hit_idx)
    );

    always_comb
    begin
        logic [CNT_W-1:0] new_cnt;
        logic [CNT_W-1:0] mc;

        new_cnt     = cnt_reg;
        mc          = '0;
        state_next  = state_reg;
        func_next   = func_reg;
        key_next    = key_reg;
        cnt_next    = cnt_reg;
        ptr_next    = ptr_reg;
        pv_next     = 1'b0;
        pa_next     = pa_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        we          = 1'b0;
        waddr       = '0;
        wdata       = key_reg;
        raddr       = '0;
        mctl.clr    = 1'b0;
        mctl.en     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    func_next = req.func;
                    key_next  = ENTRY_BITS'(req.entry);
                    mctl.clr  = 1'b1;
                    case (req.func) inside
                        FN_ADD, FN_REMOVE, FN_COUNT, FN_CONTAINS:
                        begin
                            ptr_next   = cnt_reg;
                            state_next = (cnt_reg != '0) ? ST_SCAN : ST_OUT;
                        end
                        FN_CLEAR:
                        begin
                            cnt_next   = '0;
                            state_next = ST_OUT;
                        end
                        FN_LIST:
                        begin
                            ptr_next   = cnt_reg;
                            state_next = (cnt_reg != '0) ? ST_LIST : ST_OUT;
                        end
                        default:
                        begin
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end

            // newest entry sits at the highest slot; walk downward
            ST_SCAN:
            begin
                mctl.en = pv_reg;
                if (ptr_reg != '0)
                begin
                    raddr    = AW'(ptr_reg - CNT_W'(1));
                    pa_next  = raddr;
                    pv_next  = 1'b1;
                    ptr_next = ptr_reg - CNT_W'(1);
                end
                else if (!pv_reg)
                begin
                    if (func_reg == FN_REMOVE && m_hit
                        && (CNT_W'(m_hit_idx) + CNT_W'(1)) < cnt_reg)
                    begin
                        ptr_next   = CNT_W'(m_hit_idx) + CNT_W'(1);
                        state_next = ST_SHIFT;
                    end
                    else
                    begin
                        state_next = ST_OUT;
                    end
                end
            end

            // close the gap: slot j takes slot j+1
            ST_SHIFT:
            begin
                if (ptr_reg != cnt_reg)
                begin
                    raddr    = AW'(ptr_reg);
                    pa_next  = raddr;
                    pv_next  = 1'b1;
                    ptr_next = ptr_reg + CNT_W'(1);
                end
                if (pv_reg)
                begin
                    we    = 1'b1;
                    waddr = pa_reg - AW'(1);
                    wdata = rdata;
                end
                if (ptr_reg == cnt_reg && !pv_reg)
                begin
                    state_next = ST_OUT;
                end
            end

            ST_LIST:
            begin
                if (ptr_reg != '0)
                begin
                    raddr    = AW'(ptr_reg - CNT_W'(1));
                    pa_next  = raddr;
                    pv_next  = 1'b1;
                    ptr_next = ptr_reg - CNT_W'(1);
                end
                if (pv_reg)
                begin
                    done_next               = 1'b1;
                    result_next.ok          = 1'b0;
                    result_next.match_count = '0;
                    result_next.bag_size    = 5'(cnt_reg);
                    result_next.bag_empty   = 1'b0;
                    result_next.item_valid  = 1'b1;
                    result_next.listed_item = 32'(rdata);
                    result_next.last        = (pa_reg == '0);
                end
                if (ptr_reg == '0 && !pv_reg)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_OUT:
            begin
                result_next.ok = 1'b0;
                case (func_reg)
                    FN_ADD:
                    begin
                        mc = m_count;
                        if (cnt_reg < CNT_W'(CAPACITY))
                        begin
                            we             = 1'b1;
                            waddr          = AW'(cnt_reg);
                            wdata          = key_reg;
                            new_cnt        = cnt_reg + CNT_W'(1);
                            mc             = m_count + CNT_W'(1);
                            result_next.ok = 1'b1;
                        end
                    end
                    FN_REMOVE:
                    begin
                        result_next.ok = m_hit;
                        mc             = m_count - CNT_W'(m_hit);
                        new_cnt        = cnt_reg - CNT_W'(m_hit);
                    end
                    FN_COUNT:
                    begin
                        mc = m_count;
                    end
                    FN_CONTAINS:
                    begin
                        mc             = m_count;
                        result_next.ok = (m_count != '0);
                    end
                    default:
                    begin
                        mc = '0;
                    end
                endcase
                cnt_next                = new_cnt;
                done_next               = 1'b1;
                result_next.match_count = 5'(mc);
                result_next.bag_size    = 5'(new_cnt);
                result_next.bag_empty   = (new_cnt == '0);
                result_next.item_valid  = 1'b0;
                result_next.listed_item = '0;
                result_next.last        = 1'b1;
                state_next              = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            ptr_reg   <= '0;
            pv_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ptr_reg   <= ptr_next;
            pv_reg    <= pv_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        key_reg    <= key_next;
        pa_reg     <= pa_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule
